FILE: hdl/tcsg_pkg.sv
// ----------------------------------------------------------------------------
// tcsg_pkg
// Shared word types, register indexes and rate table for the tempo clock with
// three sub-clock gates.
// ----------------------------------------------------------------------------
package tcsg_pkg;

	// one input word per sample tick
	typedef struct packed {
		logic       run_request;
		logic       sync_mode;
		logic       external_run;
		logic [9:0] external_bpm;
	} tick_word_t;

	// one result word per tick
	typedef struct packed {
		logic gate_a;
		logic gate_b;
		logic gate_c;
		logic enabled;
	} gate_word_t;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LOCAL_BPM    = 3'd0,
		CFG_STEP_PER_BPM = 3'd1,
		CFG_RATE_INDEX_A = 3'd2,
		CFG_RATE_INDEX_B = 3'd3,
		CFG_RATE_INDEX_C = 3'd4,
		CFG_OFFSET_A     = 3'd5,
		CFG_OFFSET_B     = 3'd6,
		CFG_OFFSET_C     = 3'd7
	} cfg_index_t;

	localparam logic [9:0]  LOCAL_BPM_RESET    = 10'd120;
	localparam logic [23:0] STEP_PER_BPM_RESET = 24'd381774;
	localparam logic [3:0]  RATE_INDEX_RESET   = 4'd7;
	localparam logic [16:0] OFFSET_RESET       = 17'd0;

	localparam logic [9:0]  MAX_BPM        = 10'd999;
	localparam logic [3:0]  MAX_RATE_INDEX = 4'd14;
	localparam logic [16:0] OFFSET_ONE     = 17'd65536;

	// step_per_bpm is Q0.40, offsets are Q1.16
	localparam int STEP_FRAC_BITS   = 40;
	localparam int OFFSET_FRAC_BITS = 16;
	// gate multipliers are scaled by 128
	localparam int MULT_FRAC_BITS   = 7;

	// multiplier = (triple ? 3 : 1) << shift, scaled by 128
	localparam logic [3:0] RATE_SHIFT [15] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd7, 4'd9, 4'd8, 4'd10, 4'd9, 4'd11
	};
	localparam logic RATE_TRIPLE [15] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
	};

endpackage

FILE: hdl/tempo_clock_three_sub_gates_unit.sv
// ----------------------------------------------------------------------------
// tempo_clock_three_sub_gates_unit
// Beat-time accumulator with three sub-clock gates at table rates and offsets.
// ----------------------------------------------------------------------------
//
//  channel      handshake                 payload
//  tick         tick_valid / tick_ready   tick_word (tick_word_t)
//  gates        gate_valid / gate_ready   gate_word (gate_word_t)
//  cfg          cfg_we                    cfg_index, cfg_data
//
//  one word per clock sustained while gate_ready holds high; a word passes
//  through the input register, then the result register, to gate_word
//  the only multiplier is bpm by step_per_bpm, 10 x 24 bits, in the one pass
//  stalls on gate_ready back up through the input register to tick_ready
//  reset clears time, levels and both valids; sync arms at reset
//
module tempo_clock_three_sub_gates_unit
	import tcsg_pkg::*;
#(
	parameter int FRACTION_BITS    = 32,
	parameter int TIME_LIMIT_BEATS = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_ready,
	input  tick_word_t             tick_word,
	output logic                   gate_valid,
	input  logic                   gate_ready,
	output gate_word_t             gate_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int TW = FRACTION_BITS + 8;
	localparam int SW = FRACTION_BITS + MULT_FRAC_BITS;
	localparam int INC_SHIFT = STEP_FRAC_BITS - FRACTION_BITS;
	localparam logic [TW-1:0] TIME_LIMIT = TW'(TIME_LIMIT_BEATS) << FRACTION_BITS;

	// configuration
	logic [9:0]  local_bpm_q;
	logic [23:0] step_per_bpm_q;
	logic [3:0]  rate_index_a_q, rate_index_b_q, rate_index_c_q;
	logic [16:0] offset_a_q, offset_b_q, offset_c_q;

	// state
	logic [TW-1:0] beat_time_q;
	logic          level_a_q, level_b_q, level_c_q;
	logic          sync_armed_q;

	// input register and result register
	logic       valid_s1;
	tick_word_t tick_s1;
	logic       gate_valid_q;
	gate_word_t gate_word_q;

	logic          advance;
	logic          running;
	logic          arm_clear;
	logic [9:0]    bpm_raw, bpm;
	logic [33:0]   bpm_product;
	logic [TW-1:0] increment;
	logic [TW-1:0] t_now, t_base;
	logic          base_a, base_b, base_c;
	logic          lvl_a, lvl_b, lvl_c;
	logic [TW-1:0] beat_time_next;
	logic          sync_armed_next;

	function automatic logic gate_level(
		input logic [TW-1:0] t,
		input logic [3:0]    rate,
		input logic [16:0]   off
	);
		logic [3:0]    idx;
		logic [16:0]   o;
		logic [SW-1:0] s;
		logic [SW-1:0] p;
		idx = (rate > MAX_RATE_INDEX) ? MAX_RATE_INDEX : rate;
		o   = (off > OFFSET_ONE) ? OFFSET_ONE : off;
		s   = t[SW-1:0] + (SW'(o) << (FRACTION_BITS - OFFSET_FRAC_BITS));
		p   = s << RATE_SHIFT[idx];
		if (RATE_TRIPLE[idx]) begin
			p = p + (s << (RATE_SHIFT[idx] + 4'd1));
		end
		return ~p[SW-1];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_bpm_q    <= LOCAL_BPM_RESET;
			step_per_bpm_q <= STEP_PER_BPM_RESET;
			rate_index_a_q <= RATE_INDEX_RESET;
			rate_index_b_q <= RATE_INDEX_RESET;
			rate_index_c_q <= RATE_INDEX_RESET;
			offset_a_q     <= OFFSET_RESET;
			offset_b_q     <= OFFSET_RESET;
			offset_c_q     <= OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_LOCAL_BPM:    local_bpm_q    <= cfg_data[9:0];
				CFG_STEP_PER_BPM: step_per_bpm_q <= cfg_data[23:0];
				CFG_RATE_INDEX_A: rate_index_a_q <= cfg_data[3:0];
				CFG_RATE_INDEX_B: rate_index_b_q <= cfg_data[3:0];
				CFG_RATE_INDEX_C: rate_index_c_q <= cfg_data[3:0];
				CFG_OFFSET_A:     offset_a_q     <= cfg_data[16:0];
				CFG_OFFSET_B:     offset_b_q     <= cfg_data[16:0];
				CFG_OFFSET_C:     offset_c_q     <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// handshake
	assign advance    = valid_s1 && (!gate_valid_q || gate_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick_word;
		end
	end

	// one tick of the clock
	always_comb begin
		running   = tick_s1.sync_mode ? tick_s1.external_run : tick_s1.run_request;
		arm_clear = tick_s1.sync_mode && sync_armed_q;
		bpm_raw   = tick_s1.sync_mode ? tick_s1.external_bpm : local_bpm_q;
		bpm       = (bpm_raw > MAX_BPM) ? MAX_BPM : bpm_raw;

		bpm_product = {24'd0, bpm} * {10'd0, step_per_bpm_q};
		increment   = TW'(bpm_product >> INC_SHIFT);

		t_now  = arm_clear ? '0 : beat_time_q;
		base_a = arm_clear ? 1'b0 : level_a_q;
		base_b = arm_clear ? 1'b0 : level_b_q;
		base_c = arm_clear ? 1'b0 : level_c_q;

		t_base = (t_now >= TIME_LIMIT) ? '0 : t_now;

		if (tick_s1.run_request) begin
			lvl_a = gate_level(t_now, rate_index_a_q, offset_a_q);
			lvl_b = gate_level(t_now, rate_index_b_q, offset_b_q);
			lvl_c = gate_level(t_now, rate_index_c_q, offset_c_q);
		end else begin
			lvl_a = base_a;
			lvl_b = base_b;
			lvl_c = base_c;
		end

		if (running) begin
			beat_time_next  = t_base + increment;
			sync_armed_next = !tick_s1.sync_mode;
		end else begin
			beat_time_next  = '0;
			lvl_a           = 1'b0;
			lvl_b           = 1'b0;
			lvl_c           = 1'b0;
			sync_armed_next = sync_armed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_time_q  <= '0;
			level_a_q    <= 1'b0;
			level_b_q    <= 1'b0;
			level_c_q    <= 1'b0;
			sync_armed_q <= 1'b1;
		end else if (advance) begin
			beat_time_q  <= beat_time_next;
			level_a_q    <= lvl_a;
			level_b_q    <= lvl_b;
			level_c_q    <= lvl_c;
			sync_armed_q <= sync_armed_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_valid_q <= 1'b0;
		end else if (advance) begin
			gate_valid_q <= 1'b1;
		end else if (gate_ready) begin
			gate_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gate_word_q.gate_a  <= lvl_a;
			gate_word_q.gate_b  <= lvl_b;
			gate_word_q.gate_c  <= lvl_c;
			gate_word_q.enabled <= tick_s1.run_request;
		end
	end

	assign gate_valid = gate_valid_q;
	assign gate_word  = gate_word_q;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> (valid_s1 && gate_valid_q && !gate_ready))
		else $error("input stalled while the result register could take a word");

	a_stopped_clears_gates: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !running) |=> (!gate_word_q.gate_a && !gate_word_q.gate_b
			&& !gate_word_q.gate_c && beat_time_q == '0))
		else $error("stopped tick left a gate or the time set");

	a_sync_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && running && tick_s1.sync_mode) |=> !sync_armed_q)
		else $error("running sync tick left the sync re-arm set");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && running && !tick_s1.run_request && !arm_clear)
			|=> (level_a_q == $past(level_a_q) && level_b_q == $past(level_b_q)
			&& level_c_q == $past(level_c_q)))
		else $error("gate levels moved while gates were disabled");

endmodule
